@@ design/hkrb_pkg.sv @@
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types and codes for the keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  localparam int unsigned CODE_W      = 8;
  localparam int unsigned MOD_W       = 8;
  localparam int unsigned MOD_IDX_W   = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SHOWN_SLOTS = 6;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned IN_USER_W   = 3;
  localparam int unsigned OUT_DATA_W  = MOD_W + SHOWN_SLOTS * CODE_W;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t EV_KEY_DOWN = 2'd0;
  localparam kind_t EV_KEY_UP   = 2'd1;

  // One accepted key event as seen by every cell.
  typedef struct packed {
    logic                 key_evt;
    logic                 down;
    logic                 is_mod;
    logic [MOD_IDX_W-1:0] mod_idx;
    logic [CODE_W-1:0]    code;
  } hkrb_evt_t;

endpackage

@@ design/hid_keyboard_report_builder.sv @@
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder
// Keeps a keyboard report and sends it after every event taken in, ignored kinds too.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  in_     | in  | modifier_index, usage_code         | event_kind, is_modifier
//  out_    | out | modifier_bits, key_slot_0..5       | -
//
// An event goes through the row of slot cells in the cycle it is transferred,
// and its report goes into the output register: one event per cycle unless the
// output stalls. The output register gates input: a new event is taken once the
// held report is transferred or in that same cycle. Reset empties the report.
module hid_keyboard_report_builder #(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] modifier_index, [10:3] usage_code, [15:11] zero
  input  logic [hkrb_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] event_kind, [2] is_modifier
  input  logic [hkrb_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] modifier_bits, then key_slot_0 to key_slot_5, eight bits each
  output logic [hkrb_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import hkrb_pkg::*;

  logic                  in_xfer;
  kind_t                 kind;
  hkrb_evt_t             evt;
  logic [SLOT_COUNT:0]   taken;
  logic [CODE_W-1:0]     slot_nxt [SLOT_COUNT];
  logic [CODE_W-1:0]     shown [SHOWN_SLOTS];
  logic [MOD_W-1:0]      mod_nxt;
  logic [OUT_DATA_W-1:0] report;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign kind      = in_tuser[KIND_W-1:0];

  assign evt.key_evt = in_xfer && ((kind == EV_KEY_DOWN) || (kind == EV_KEY_UP));
  assign evt.down    = (kind == EV_KEY_DOWN);
  assign evt.is_mod  = in_tuser[KIND_W];
  assign evt.mod_idx = in_tdata[MOD_IDX_W-1:0];
  assign evt.code    = in_tdata[MOD_IDX_W +: CODE_W];

  hkrb_mod_cell u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt     (evt),
    .mod_nxt (mod_nxt)
  );

  assign taken[0] = 1'b0;

  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
    hkrb_slot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .evt       (evt),
      .taken_in  (taken[k]),
      .taken_out (taken[k+1]),
      .slot_nxt  (slot_nxt[k])
    );
  end

  for (genvar k = 0; k < SHOWN_SLOTS; k++) begin : g_shown
    if (k < SLOT_COUNT) begin : g_used
      assign shown[k] = slot_nxt[k];
    end else begin : g_empty
      assign shown[k] = '0;
    end
    assign report[MOD_W + k*CODE_W +: CODE_W] = shown[k];
  end

  assign report[MOD_W-1:0] = mod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_xfer) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_tdata_r <= report;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ design/hkrb_slot_cell.sv @@
// ----------------------------------------------------------------------------
// hkrb_slot_cell
// One key slot. Claims the event when no earlier cell has and it matches.
// ----------------------------------------------------------------------------
module hkrb_slot_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hkrb_pkg::hkrb_evt_t      evt,
  input  logic                     taken_in,
  output logic                     taken_out,
  output logic [hkrb_pkg::CODE_W-1:0] slot_nxt
);
  import hkrb_pkg::*;

  logic [CODE_W-1:0] slot_r;
  logic              upd;
  logic              match;
  logic              hit;

  assign upd       = evt.key_evt && !evt.is_mod && (evt.code != '0);
  assign match     = evt.down ? (slot_r == '0) : (slot_r == evt.code);
  assign hit       = upd && !taken_in && match;
  assign taken_out = taken_in || match;

  always_comb begin
    slot_nxt = slot_r;
    if (hit) begin
      slot_nxt = evt.down ? evt.code : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

@@ design/hkrb_mod_cell.sv @@
// ----------------------------------------------------------------------------
// hkrb_mod_cell
// Modifier bitmap of the report.
// ----------------------------------------------------------------------------
module hkrb_mod_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hkrb_pkg::hkrb_evt_t        evt,
  output logic [hkrb_pkg::MOD_W-1:0] mod_nxt
);
  import hkrb_pkg::*;

  logic [MOD_W-1:0] mod_r;
  logic [MOD_W-1:0] mask;

  assign mask = MOD_W'(1) << evt.mod_idx;

  always_comb begin
    mod_nxt = mod_r;
    if (evt.key_evt && evt.is_mod) begin
      mod_nxt = evt.down ? (mod_r | mask) : (mod_r & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
    end else begin
      mod_r <= mod_nxt;
    end
  end

endmodule

@@ design/hkrb_checker.sv @@
// ----------------------------------------------------------------------------
// hkrb_checker
// Port-level checks for the keyboard report builder.
// ----------------------------------------------------------------------------
module hkrb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hkrb_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import hkrb_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Report shown right after reset.");

  a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("Transfer in gave no report.");

  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("Event taken while a report was still held.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("Stalled report changed.");

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/tb_hid_keyboard_report_builder.sv @@
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_builder
// Drives key, modifier and ignored events into the report builder and checks
// every report it sends against a report kept in parallel by the testbench.
// Runs a directed opening, then random keystroke sequences under four
// patterns of input gaps and output stalls, with a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hid_keyboard_report_builder;
  import hkrb_pkg::*;

  localparam int unsigned SLOTS       = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 200000;
  localparam int unsigned PER_PHASE   = 406;

  localparam kind_t EV_OTHER = 2'd2;
  localparam kind_t EV_SPARE = 2'd3;

  typedef logic [OUT_DATA_W-1:0] report_t;

  class report_book;
    logic [MOD_W-1:0]  mods;
    logic [CODE_W-1:0] slots[SLOTS];
    report_t           reports_due[$];
    int unsigned       mismatches;
    int unsigned       dropped_presses;
    int unsigned       absent_releases;

    function new();
      mods = '0;
      foreach (slots[k]) slots[k] = '0;
      mismatches = 0;
      dropped_presses = 0;
      absent_releases = 0;
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    function void take_event(kind_t kind, logic is_mod, logic [MOD_IDX_W-1:0] idx,
                             logic [CODE_W-1:0] code);
      logic              down;
      logic              done;
      logic [CODE_W-1:0] match;
      report_t           rep;
      down = (kind == EV_KEY_DOWN);
      done = 1'b0;
      if (kind == EV_KEY_DOWN || kind == EV_KEY_UP) begin
        if (is_mod) begin
          mods[idx] = down;
        end else if (code != '0) begin
          match = down ? '0 : code;
          for (int k = 0; k < SLOTS; k++) begin
            if (!done && slots[k] == match) begin
              slots[k] = down ? code : '0;
              done = 1'b1;
            end
          end
          if (!done && down) dropped_presses++;
          if (!done && !down) absent_releases++;
        end
      end
      rep = '0;
      rep[MOD_W-1:0] = mods;
      for (int k = 0; k < SHOWN_SLOTS; k++) begin
        if (k < SLOTS) rep[MOD_W + k*CODE_W +: CODE_W] = slots[k];
      end
      reports_due.push_back(rep);
    endfunction

    function void check_report(report_t got);
      report_t want;
      string   name;
      if (reports_due.size() == 0) begin
        report_mismatch($sformatf("report %h arrived with none expected", got));
        return;
      end
      want = reports_due.pop_front();
      for (int f = 0; f <= SHOWN_SLOTS; f++) begin
        name = (f == 0) ? "modifier_bits" : $sformatf("key_slot_%0d", f - 1);
        if (got[f*8 +: 8] !== want[f*8 +: 8])
          report_mismatch($sformatf("%s got %h, expected %h", name, got[f*8 +: 8],
                                    want[f*8 +: 8]));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  report_book book = new();

  int unsigned       cycles = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  logic              hold_start = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       keystrokes = 0;
  int unsigned       n_down = 0;
  int unsigned       n_up = 0;
  int unsigned       n_mod = 0;
  int unsigned       n_other = 0;
  logic [CODE_W-1:0] held[$];

  hid_keyboard_report_builder #(.SLOT_COUNT(SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, book.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the ready level for the next edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_report(out_tdata);
    if (hold_start) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_event(kind_t kind, logic is_mod, logic [MOD_IDX_W-1:0] idx,
                            logic [CODE_W-1:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - CODE_W - MOD_IDX_W){1'b0}}, code, idx};
    in_tuser  <= {is_mod, kind};
    do @(posedge clk); while (!in_tready);
    book.take_event(kind, is_mod, idx, code);
    if (kind == EV_KEY_DOWN || kind == EV_KEY_UP) begin
      keystrokes++;
      if (is_mod) n_mod++;
      else if (kind == EV_KEY_DOWN) n_down++;
      else n_up++;
    end else begin
      n_other++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly plausible typing: presses of new keys and releases of held ones,
  // with modifier traffic, ignored events and fully random items mixed in.
  task automatic random_keystroke();
    int unsigned           roll;
    int unsigned           pick;
    kind_t                 kind;
    logic                  is_mod;
    logic [MOD_IDX_W-1:0]  idx;
    logic [CODE_W-1:0]     code;
    roll   = $urandom_range(0, 99);
    kind   = EV_KEY_DOWN;
    is_mod = 1'b0;
    idx    = MOD_IDX_W'($urandom_range(0, 7));
    code   = '0;
    if (held.size() > SLOTS + 1) roll = 50;
    if (roll < 38) begin
      if (held.size() != 0 && $urandom_range(0, 19) == 0)
        code = held[$urandom_range(0, held.size() - 1)];
      else
        code = CODE_W'($urandom_range(1, 255));
      held.push_back(code);
    end else if (roll < 72) begin
      kind = EV_KEY_UP;
      if (held.size() != 0) begin
        pick = $urandom_range(0, held.size() - 1);
        code = held[pick];
        held.delete(pick);
      end else begin
        code = CODE_W'($urandom_range(1, 255));
      end
    end else if (roll < 86) begin
      kind   = $urandom_range(0, 1) ? EV_KEY_UP : EV_KEY_DOWN;
      is_mod = 1'b1;
      code   = CODE_W'($urandom);
    end else if (roll < 93) begin
      kind   = $urandom_range(0, 1) ? EV_SPARE : EV_OTHER;
      is_mod = 1'($urandom);
      code   = CODE_W'($urandom);
    end else begin
      kind   = kind_t'($urandom);
      is_mod = 1'($urandom);
      code   = CODE_W'($urandom);
    end
    send_event(kind, is_mod, idx, code);
  endtask

  initial begin
    int unsigned target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: ignored kinds, no mapping, filling and overfilling the
    // report, duplicates, absent releases and modifier precedence.
    send_event(EV_OTHER,    1'b1, 3'd7, 8'hFF);
    send_event(EV_SPARE,    1'b1, 3'd7, 8'hFF);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h00);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h04);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'hFF);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h04);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h01);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h80);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h55);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'hAA);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h04);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h33);
    send_event(EV_KEY_DOWN, 1'b0, 3'd0, 8'h2A);
    send_event(EV_KEY_DOWN, 1'b1, 3'd0, 8'h39);
    send_event(EV_KEY_DOWN, 1'b1, 3'd7, 8'h00);
    send_event(EV_KEY_DOWN, 1'b1, 3'd5, 8'h00);
    send_event(EV_KEY_UP,   1'b1, 3'd0, 8'hFF);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h00);
    send_event(EV_SPARE,    1'b1, 3'd2, 8'h00);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'hFF);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h04);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h01);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h80);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h55);
    send_event(EV_KEY_UP,   1'b0, 3'd0, 8'h2A);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 28 : 0;
      stall_pct    <= (ph == 2) ? 50 : (ph == 3) ? 28 : 0;
      target = keystrokes + n_other + PER_PHASE;
      if (ph == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      while (keystrokes + n_other < target) random_keystroke();
      wait_drained();
    end

    stall_pct <= 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (book.pending() != 0)
      book.report_mismatch($sformatf("%0d reports never arrived", book.pending()));

    $display("covered %0d presses, %0d releases, %0d modifier and %0d ignored events",
             n_down, n_up, n_mod, n_other);
    $display("%0d presses dropped on a full report, %0d releases of absent keys",
             book.dropped_presses, book.absent_releases);
    if (book.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ hid_keyboard_report_builder.f @@
design/hkrb_pkg.sv
design/hkrb_slot_cell.sv
design/hkrb_mod_cell.sv
design/hid_keyboard_report_builder.sv
design/hkrb_checker.sv
tb/tb_hid_keyboard_report_builder.sv
